>>> rtl/core/adsr_env_pkg.sv
package adsr_env_pkg;

    // register byte addresses on the configuration port
    localparam int ADDR_BITS = 5;

    localparam logic [ADDR_BITS-1:0] ADDR_MODE          = 5'h00;
    localparam logic [ADDR_BITS-1:0] ADDR_ATTACK_LEN    = 5'h04;
    localparam logic [ADDR_BITS-1:0] ADDR_DECAY_LEN     = 5'h08;
    localparam logic [ADDR_BITS-1:0] ADDR_RELEASE_LEN   = 5'h0c;
    localparam logic [ADDR_BITS-1:0] ADDR_TOTAL_LEN     = 5'h10;
    localparam logic [ADDR_BITS-1:0] ADDR_PEAK_LEVEL    = 5'h14;
    localparam logic [ADDR_BITS-1:0] ADDR_SUSTAIN_LEVEL = 5'h18;

    localparam logic MODE_ADSR = 1'b0;
    localparam logic MODE_ASR  = 1'b1;

    // how the quotient turns into the final level
    typedef enum logic [2:0] {
        KIND_ZERO,
        KIND_DIRECT,
        KIND_ADD,
        KIND_SUB,
        KIND_CONST
    } level_kind_t;

    typedef struct packed {
        level_kind_t kind;
        logic        oor;
    } seg_ctl_t;

endpackage

>>> rtl/core/adsr_env_front.sv
module adsr_env_front
    import adsr_env_pkg::*;
#(
    parameter int LEN_BITS   = 16,
    parameter int LEVEL_BITS = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [LEN_BITS-1:0]               sample_index,
    input  logic                              mode,
    input  logic [LEN_BITS-1:0]               attack_len,
    input  logic [LEN_BITS-1:0]               decay_len,
    input  logic [LEN_BITS-1:0]               release_len,
    input  logic [LEN_BITS-1:0]               total_len,
    input  logic [LEVEL_BITS-1:0]             peak_level,
    input  logic [LEVEL_BITS-1:0]             sustain_level,
    output logic                              out_valid,
    output logic [LEN_BITS+LEVEL_BITS-1:0]    out_product,
    output logic [LEN_BITS-1:0]               out_den,
    output logic [LEVEL_BITS-1:0]             out_base,
    output seg_ctl_t                          out_ctl
);

    logic [LEVEL_BITS-1:0] peak_eff;
    logic [LEN_BITS-1:0]   decay_eff;
    logic [LEN_BITS:0]     attack_plus_decay;
    logic [LEN_BITS:0]     index_plus_release;

    logic [LEVEL_BITS-1:0] x_next;
    logic [LEN_BITS-1:0]   y_next;
    logic [LEN_BITS-1:0]   den_next;
    logic [LEVEL_BITS-1:0] base_next;
    seg_ctl_t              ctl_next;

    logic                  valid_a_reg;
    logic [LEVEL_BITS-1:0] x_a_reg;
    logic [LEN_BITS-1:0]   y_a_reg;
    logic [LEN_BITS-1:0]   den_a_reg;
    logic [LEVEL_BITS-1:0] base_a_reg;
    seg_ctl_t              ctl_a_reg;

    logic                           valid_b_reg;
    logic [LEN_BITS+LEVEL_BITS-1:0] product_b_reg;
    logic [LEN_BITS-1:0]            den_b_reg;
    logic [LEVEL_BITS-1:0]          base_b_reg;
    seg_ctl_t                       ctl_b_reg;

    assign peak_eff           = (mode == MODE_ASR) ? sustain_level : peak_level;
    assign decay_eff          = (mode == MODE_ASR) ? '0 : decay_len;
    assign attack_plus_decay  = {1'b0, attack_len} + {1'b0, decay_eff};
    assign index_plus_release = {1'b0, sample_index} + {1'b0, release_len};

    // segment select, first test that holds wins
    always_comb
    begin
        x_next        = '0;
        y_next        = '0;
        den_next      = '0;
        base_next     = '0;
        ctl_next.kind = KIND_ZERO;
        ctl_next.oor  = 1'b0;
        priority if (sample_index >= total_len)
        begin
            ctl_next.oor = 1'b1;
        end
        else if (sample_index <= attack_len)
        begin
            x_next        = peak_eff;
            y_next        = sample_index;
            den_next      = attack_len;
            ctl_next.kind = (attack_len == '0) ? KIND_ZERO : KIND_DIRECT;
        end
        else if ({1'b0, sample_index} <= attack_plus_decay)
        begin
            y_next    = sample_index - attack_len;
            den_next  = decay_eff;
            base_next = peak_eff;
            if (peak_eff >= sustain_level)
            begin
                x_next        = peak_eff - sustain_level;
                ctl_next.kind = KIND_SUB;
            end
            else
            begin
                x_next        = sustain_level - peak_eff;
                ctl_next.kind = KIND_ADD;
            end
        end
        else if (index_plus_release <= {1'b0, total_len})
        begin
            base_next     = sustain_level;
            ctl_next.kind = KIND_CONST;
        end
        else
        begin
            x_next        = sustain_level;
            y_next        = total_len - sample_index;
            den_next      = release_len;
            ctl_next.kind = KIND_DIRECT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_a_reg       <= x_next;
            y_a_reg       <= y_next;
            den_a_reg     <= den_next;
            base_a_reg    <= base_next;
            ctl_a_reg     <= ctl_next;
            product_b_reg <= x_a_reg * y_a_reg;
            den_b_reg     <= den_a_reg;
            base_b_reg    <= base_a_reg;
            ctl_b_reg     <= ctl_a_reg;
        end
    end

    assign out_valid   = valid_b_reg;
    assign out_product = product_b_reg;
    assign out_den     = den_b_reg;
    assign out_base    = base_b_reg;
    assign out_ctl     = ctl_b_reg;

endmodule

>>> rtl/core/adsr_env_cell.sv
module adsr_env_cell
    import adsr_env_pkg::*;
#(
    parameter int LEN_BITS   = 16,
    parameter int LEVEL_BITS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [LEN_BITS-1:0]   in_rem,
    input  logic [LEVEL_BITS-1:0] in_low,
    input  logic [LEN_BITS-1:0]   in_den,
    input  logic [LEVEL_BITS-1:0] in_base,
    input  seg_ctl_t              in_ctl,
    output logic                  out_valid,
    output logic [LEN_BITS-1:0]   out_rem,
    output logic [LEVEL_BITS-1:0] out_low,
    output logic [LEN_BITS-1:0]   out_den,
    output logic [LEVEL_BITS-1:0] out_base,
    output seg_ctl_t              out_ctl
);

    // one restoring step: low holds unused dividend bits on top, quotient bits below
    logic [LEN_BITS:0]     trial;
    logic [LEN_BITS:0]     diff;
    logic                  fits;

    logic                  valid_reg;
    logic [LEN_BITS-1:0]   rem_reg;
    logic [LEVEL_BITS-1:0] low_reg;
    logic [LEN_BITS-1:0]   den_reg;
    logic [LEVEL_BITS-1:0] base_reg;
    seg_ctl_t              ctl_reg;

    assign trial = {in_rem, in_low[LEVEL_BITS-1]};
    assign diff  = trial - {1'b0, in_den};
    assign fits  = (trial >= {1'b0, in_den});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= fits ? diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
            low_reg  <= {in_low[LEVEL_BITS-2:0], fits};
            den_reg  <= in_den;
            base_reg <= in_base;
            ctl_reg  <= in_ctl;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_low   = low_reg;
    assign out_den   = den_reg;
    assign out_base  = base_reg;
    assign out_ctl   = ctl_reg;

endmodule

>>> rtl/core/adsr_envelope_level.sv
// linear adsr / asr envelope level, one sample index in, one level out
// stages: select and product registers, LEVEL_BITS divider cells, output register
// throughput: one request per cycle unless m_* is held, set by the LEVEL_BITS divider
// cells (one quotient bit per cell) behind a registered LEN_BITS x LEVEL_BITS multiply
// reset: rst_n async active low, empties the pipe, config registers go to reset values
module adsr_envelope_level
    import adsr_env_pkg::*;
#(
    parameter int LEN_BITS   = 16,
    parameter int LEVEL_BITS = 16
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration port
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ADDR_BITS-1:0]                paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    // request stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [((LEN_BITS+7)/8)*8-1:0]       s_tdata,  // sample_index
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [((LEVEL_BITS+7)/8)*8-1:0]     m_tdata,  // level
    output logic                                m_tuser   // out_of_range
);

    localparam int NUM_BITS = LEN_BITS + LEVEL_BITS;

    // configuration registers
    logic                  mode_reg;
    logic [LEN_BITS-1:0]   attack_len_reg;
    logic [LEN_BITS-1:0]   decay_len_reg;
    logic [LEN_BITS-1:0]   release_len_reg;
    logic [LEN_BITS-1:0]   total_len_reg;
    logic [LEVEL_BITS-1:0] peak_level_reg;
    logic [LEVEL_BITS-1:0] sustain_level_reg;
    logic                  cfg_write;

    // whole pipe moves together, stalls only when the output register is full and held
    logic                  pipe_en;

    // front end to the cell row
    logic                  front_valid;
    logic [NUM_BITS-1:0]   front_product;
    logic [LEN_BITS-1:0]   front_den;
    logic [LEVEL_BITS-1:0] front_base;
    seg_ctl_t              front_ctl;

    // links of the divider row, link 0 feeds the first cell
    logic                  link_valid [0:LEVEL_BITS];
    logic [LEN_BITS-1:0]   link_rem   [0:LEVEL_BITS];
    logic [LEVEL_BITS-1:0] link_low   [0:LEVEL_BITS];
    logic [LEN_BITS-1:0]   link_den   [0:LEVEL_BITS];
    logic [LEVEL_BITS-1:0] link_base  [0:LEVEL_BITS];
    seg_ctl_t              link_ctl   [0:LEVEL_BITS];

    // output register
    logic                  out_valid_reg;
    logic [LEVEL_BITS-1:0] level_reg;
    logic                  oor_reg;
    logic [LEVEL_BITS-1:0] level_next;
    logic [LEVEL_BITS-1:0] quotient;

    //--------------------------------------------------------------------------
    // register file, written on the access phase, always ready
    //--------------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg          <= MODE_ADSR;
            attack_len_reg    <= '0;
            decay_len_reg     <= '0;
            release_len_reg   <= '0;
            total_len_reg     <= '0;
            peak_level_reg    <= LEVEL_BITS'(32'd65535);
            sustain_level_reg <= LEVEL_BITS'(32'd32768);
        end
        else if (cfg_write)
        begin
            unique case (paddr)
                ADDR_MODE:          mode_reg          <= pwdata[0];
                ADDR_ATTACK_LEN:    attack_len_reg    <= pwdata[LEN_BITS-1:0];
                ADDR_DECAY_LEN:     decay_len_reg     <= pwdata[LEN_BITS-1:0];
                ADDR_RELEASE_LEN:   release_len_reg   <= pwdata[LEN_BITS-1:0];
                ADDR_TOTAL_LEN:     total_len_reg     <= pwdata[LEN_BITS-1:0];
                ADDR_PEAK_LEVEL:    peak_level_reg    <= pwdata[LEVEL_BITS-1:0];
                ADDR_SUSTAIN_LEVEL: sustain_level_reg <= pwdata[LEVEL_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // read back, unmapped addresses read as zero
    always_comb
    begin
        unique case (paddr)
            ADDR_MODE:          prdata = 32'(mode_reg);
            ADDR_ATTACK_LEN:    prdata = 32'(attack_len_reg);
            ADDR_DECAY_LEN:     prdata = 32'(decay_len_reg);
            ADDR_RELEASE_LEN:   prdata = 32'(release_len_reg);
            ADDR_TOTAL_LEN:     prdata = 32'(total_len_reg);
            ADDR_PEAK_LEVEL:    prdata = 32'(peak_level_reg);
            ADDR_SUSTAIN_LEVEL: prdata = 32'(sustain_level_reg);
            default:            prdata = '0;
        endcase
    end

    //--------------------------------------------------------------------------
    // flow control: a request is taken whenever the output slot is free or draining
    //--------------------------------------------------------------------------
    assign pipe_en  = !out_valid_reg || m_tready;
    assign s_tready = pipe_en;

    //--------------------------------------------------------------------------
    // segment classification and numerator product, two stages
    //--------------------------------------------------------------------------
    adsr_env_front #(
        .LEN_BITS   (LEN_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (pipe_en),
        .in_valid      (s_tvalid),
        .sample_index  (s_tdata[LEN_BITS-1:0]),
        .mode          (mode_reg),
        .attack_len    (attack_len_reg),
        .decay_len     (decay_len_reg),
        .release_len   (release_len_reg),
        .total_len     (total_len_reg),
        .peak_level    (peak_level_reg),
        .sustain_level (sustain_level_reg),
        .out_valid     (front_valid),
        .out_product   (front_product),
        .out_den       (front_den),
        .out_base      (front_base),
        .out_ctl       (front_ctl)
    );

    // the top LEN_BITS of the product are always below the divisor for the
    // segments that divide, since the quotient never exceeds a level
    assign link_valid[0] = front_valid;
    assign link_rem[0]   = front_product[NUM_BITS-1:LEVEL_BITS];
    assign link_low[0]   = front_product[LEVEL_BITS-1:0];
    assign link_den[0]   = front_den;
    assign link_base[0]  = front_base;
    assign link_ctl[0]   = front_ctl;

    //--------------------------------------------------------------------------
    // divider row: one cell per quotient bit, msb first
    //--------------------------------------------------------------------------
    generate
        for (genvar g = 0; g < LEVEL_BITS; g++)
        begin : g_cell
            adsr_env_cell #(
                .LEN_BITS   (LEN_BITS),
                .LEVEL_BITS (LEVEL_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (pipe_en),
                .in_valid  (link_valid[g]),
                .in_rem    (link_rem[g]),
                .in_low    (link_low[g]),
                .in_den    (link_den[g]),
                .in_base   (link_base[g]),
                .in_ctl    (link_ctl[g]),
                .out_valid (link_valid[g+1]),
                .out_rem   (link_rem[g+1]),
                .out_low   (link_low[g+1]),
                .out_den   (link_den[g+1]),
                .out_base  (link_base[g+1]),
                .out_ctl   (link_ctl[g+1])
            );
        end
    endgenerate

    //--------------------------------------------------------------------------
    // final level: quotient alone, added to or taken from the peak, or a constant
    //--------------------------------------------------------------------------
    assign quotient = link_low[LEVEL_BITS];

    always_comb
    begin
        unique case (link_ctl[LEVEL_BITS].kind)
            KIND_ZERO:   level_next = '0;
            KIND_DIRECT: level_next = quotient;
            KIND_ADD:    level_next = link_base[LEVEL_BITS] + quotient;
            KIND_SUB:    level_next = link_base[LEVEL_BITS] - quotient;
            KIND_CONST:  level_next = link_base[LEVEL_BITS];
            default:     level_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            out_valid_reg <= link_valid[LEVEL_BITS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            level_reg <= level_next;
            oor_reg   <= link_ctl[LEVEL_BITS].oor;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = (((LEVEL_BITS+7)/8)*8)'(level_reg);
    assign m_tuser  = oor_reg;

endmodule

>>> dv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import adsr_env_pkg::*;

    localparam int LEN_BITS       = 16;
    localparam int LEVEL_BITS     = 16;
    localparam int PIPE_LATENCY   = LEVEL_BITS + 3;
    localparam int HOLD_OFF_CYCLES = 300;
    // worst quiet spell: the long receiver hold-off plus a settle and a full reprogram
    localparam int WATCHDOG_LIMIT = 5000;

    // which piece of the envelope an index falls in, for the run summary
    typedef enum logic [2:0] {
        SEG_OUT,
        SEG_ATTACK,
        SEG_DECAY,
        SEG_SUSTAIN,
        SEG_RELEASE
    } segment_t;

    typedef enum int {
        REG_MODE,
        REG_ATTACK,
        REG_DECAY,
        REG_RELEASE,
        REG_TOTAL,
        REG_PEAK,
        REG_SUSTAIN
    } reg_index_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] level;
        logic                  out_of_range;
    } envelope_point_t;

    typedef struct {
        logic                  mode;
        logic [LEN_BITS-1:0]   atk_len;
        logic [LEN_BITS-1:0]   dcy_len;
        logic [LEN_BITS-1:0]   rel_len;
        logic [LEN_BITS-1:0]   tot_len;
        logic [LEVEL_BITS-1:0] peak;
        logic [LEVEL_BITS-1:0] sustain;
    } envelope_shape_t;

    logic                      clk      = 1'b0;
    logic                      rst_n    = 1'b0;
    logic                      psel     = 1'b0;
    logic                      penable  = 1'b0;
    logic                      pwrite   = 1'b0;
    logic [ADDR_BITS-1:0]      paddr    = '0;
    logic [31:0]               pwdata   = '0;
    logic [31:0]               prdata;
    logic                      pready;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [((LEN_BITS+7)/8)*8-1:0]   s_tdata = '0;   // sample_index
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [((LEVEL_BITS+7)/8)*8-1:0] m_tdata;        // level
    logic                      m_tuser;              // out_of_range

    // shadow of the block's registers, as seen by the level predictor
    envelope_shape_t shape;
    // levels still owed by the block, oldest first
    envelope_point_t pending_points[$];

    bit send_gaps = 1'b1;
    bit recv_gaps = 1'b1;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int idle_cycles   = 0;
    int errors        = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int shapes_applied  = 0;
    int asr_shapes      = 0;
    int seg_hits[5]     = '{default: 0};

    always #4 clk = ~clk;

    adsr_envelope_level #(
        .LEN_BITS   (LEN_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // ------------------------------------------------------------------
    // level predictor: evaluates the envelope at one index from the shadow
    // registers, tests taken in order and the first one that holds wins
    // ------------------------------------------------------------------
    function automatic segment_t envelope_point(input logic [LEN_BITS-1:0] idx,
                                                output envelope_point_t pt);
        longint a;
        longint d;
        longint r;
        longint t;
        longint s;
        longint p;
        longint i;
        longint lv;
        segment_t seg;
        a  = shape.atk_len;
        d  = shape.dcy_len;
        r  = shape.rel_len;
        t  = shape.tot_len;
        s  = shape.sustain;
        p  = shape.peak;
        i  = idx;
        lv = 0;
        pt.out_of_range = 1'b0;
        // asr shape: no decay, attack climbs straight to the sustain level
        if (shape.mode == MODE_ASR)
        begin
            p = s;
            d = 0;
        end
        if (i >= t)
        begin
            pt.out_of_range = 1'b1;
            seg = SEG_OUT;
        end
        else if (i <= a)
        begin
            // zero attack length gives 0 at index 0 without dividing
            seg = SEG_ATTACK;
            lv  = (a == 0) ? 0 : (i * p) / a;
        end
        else if (i <= a + d)
        begin
            // signed quotient truncated toward zero, so sustain above peak ramps up
            seg = SEG_DECAY;
            lv  = p - ((p - s) * (i - a)) / d;
        end
        else if (i <= t - r)
        begin
            // signed compare: a release longer than the total never reaches here
            seg = SEG_SUSTAIN;
            lv  = s;
        end
        else
        begin
            seg = SEG_RELEASE;
            lv  = (r <= 0) ? 0 : (s * (t - i)) / r;
        end
        if (lv < 0)
            lv = 0;
        pt.level = lv[LEVEL_BITS-1:0];
        return seg;
    endfunction

    function automatic void note_error(input string msg);
        errors++;
        $display("%0t: %s", $time, msg);
    endfunction

    // ------------------------------------------------------------------
    // request side: one sample index per call, with random idle cycles in
    // front; the handshake is judged at the falling edge, where both sides
    // are settled, and the request is taken at the following rising edge
    // ------------------------------------------------------------------
    task automatic send_request(input logic [LEN_BITS-1:0] idx);
        envelope_point_t pt;
        segment_t seg;
        while (send_gaps && $urandom_range(0, 99) < 33)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= idx;
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        seg = envelope_point(idx, pt);
        seg_hits[seg]++;
        pending_points.push_back(pt);
        requests_sent++;
    endtask

    // sender stops and waits for every owed level, then lets the pipe settle
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY) @(posedge clk);
    endtask

    function automatic logic [ADDR_BITS-1:0] reg_addr(input reg_index_t which);
        case (which)
            REG_MODE:    return ADDR_MODE;
            REG_ATTACK:  return ADDR_ATTACK_LEN;
            REG_DECAY:   return ADDR_DECAY_LEN;
            REG_RELEASE: return ADDR_RELEASE_LEN;
            REG_TOTAL:   return ADDR_TOTAL_LEN;
            REG_PEAK:    return ADDR_PEAK_LEVEL;
            default:     return ADDR_SUSTAIN_LEVEL;
        endcase
    endfunction

    // register value as the block should hold it, bits above its width dropped
    function automatic logic [31:0] shadow_value(input reg_index_t which);
        case (which)
            REG_MODE:    return {31'd0, shape.mode};
            REG_ATTACK:  return {16'd0, shape.atk_len};
            REG_DECAY:   return {16'd0, shape.dcy_len};
            REG_RELEASE: return {16'd0, shape.rel_len};
            REG_TOTAL:   return {16'd0, shape.tot_len};
            REG_PEAK:    return {16'd0, shape.peak};
            default:     return {16'd0, shape.sustain};
        endcase
    endfunction

    // setup, access, then idle with psel low so that back-to-back calls never
    // lower and raise psel in the same step
    task automatic apb_cycle(input reg_index_t which, input bit is_write,
                             input logic [31:0] value, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= is_write;
        paddr   <= reg_addr(which);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(negedge clk); while (!pready);
        rdata = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_register(input reg_index_t which, input logic [31:0] value);
        logic [31:0] unused;
        apb_cycle(which, 1'b1, value, unused);
        case (which)
            REG_MODE:    shape.mode    = value[0];
            REG_ATTACK:  shape.atk_len = value[LEN_BITS-1:0];
            REG_DECAY:   shape.dcy_len = value[LEN_BITS-1:0];
            REG_RELEASE: shape.rel_len = value[LEN_BITS-1:0];
            REG_TOTAL:   shape.tot_len = value[LEN_BITS-1:0];
            REG_PEAK:    shape.peak    = value[LEVEL_BITS-1:0];
            default:     shape.sustain = value[LEVEL_BITS-1:0];
        endcase
    endtask

    // read every register back and compare against the shadow, width only
    task automatic check_registers();
        logic [31:0] rdata;
        logic [31:0] want;
        logic [31:0] mask;
        for (int k = REG_MODE; k <= REG_SUSTAIN; k++)
        begin
            apb_cycle(reg_index_t'(k), 1'b0, 32'd0, rdata);
            want = shadow_value(reg_index_t'(k));
            mask = (k == REG_MODE) ? 32'h1 : 32'hffff;
            if ((rdata & mask) !== want)
                note_error($sformatf("register %0d readback, expected %h got %h",
                                     k, want, rdata & mask));
        end
    endtask

    // reprogram the whole shape once idle; the upper bits carry junk that
    // the block must drop
    task automatic apply_shape(input envelope_shape_t next);
        logic [31:0] junk;
        wait_drained();
        junk = $urandom;
        write_register(REG_MODE,    {junk[31:1], next.mode});
        junk = $urandom;
        write_register(REG_ATTACK,  {junk[31:16], next.atk_len});
        junk = $urandom;
        write_register(REG_DECAY,   {junk[31:16], next.dcy_len});
        junk = $urandom;
        write_register(REG_RELEASE, {junk[31:16], next.rel_len});
        junk = $urandom;
        write_register(REG_TOTAL,   {junk[31:16], next.tot_len});
        junk = $urandom;
        write_register(REG_PEAK,    {junk[31:16], next.peak});
        junk = $urandom;
        write_register(REG_SUSTAIN, {junk[31:16], next.sustain});
        check_registers();
        shapes_applied++;
        if (next.mode == MODE_ASR)
            asr_shapes++;
    endtask

    // mostly short segments so that every piece is reached, sometimes the extremes
    function automatic logic [15:0] pick_len();
        case ($urandom_range(0, 9))
            0:          return 16'd0;
            1:          return 16'hffff;
            2, 3, 4, 5: return 16'($urandom_range(1, 40));
            default:    return 16'($urandom_range(0, 3000));
        endcase
    endfunction

    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'hffff;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic envelope_shape_t random_shape();
        envelope_shape_t sh;
        int sum;
        sh.mode    = ($urandom_range(0, 99) < 30) ? MODE_ASR : MODE_ADSR;
        sh.atk_len = pick_len();
        sh.dcy_len = pick_len();
        sh.rel_len = pick_len();
        // usually a total that leaves room for a sustain, otherwise anything
        if ($urandom_range(0, 9) < 6)
        begin
            sum = sh.atk_len + sh.dcy_len + sh.rel_len + $urandom_range(0, 60);
            sh.tot_len = (sum > 65535) ? 16'hffff : 16'(sum);
        end
        else
            sh.tot_len = pick_len();
        sh.peak    = pick_level();
        sh.sustain = pick_level();
        return sh;
    endfunction

    function automatic int clamp_index(input int v);
        if (v < 0)
            return 0;
        if (v > 65535)
            return 65535;
        return v;
    endfunction

    // index biased into the envelope and onto the segment edges
    function automatic logic [15:0] pick_index();
        int a;
        int d;
        int r;
        int t;
        int edge_idx;
        a = shape.atk_len;
        d = (shape.mode == MODE_ASR) ? 0 : int'(shape.dcy_len);
        r = shape.rel_len;
        t = shape.tot_len;
        case ($urandom_range(0, 9))
            0, 1:
                return 16'($urandom_range(0, 65535));
            2:
            begin
                case ($urandom_range(0, 7))
                    0:       edge_idx = a;
                    1:       edge_idx = a + 1;
                    2:       edge_idx = a + d;
                    3:       edge_idx = a + d + 1;
                    4:       edge_idx = t - r;
                    5:       edge_idx = t - r + 1;
                    6:       edge_idx = t - 1;
                    default: edge_idx = t;
                endcase
                return 16'(clamp_index(edge_idx));
            end
            default:
                return 16'($urandom_range(0, clamp_index(t + 3)));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result side: ready toggles at random, a requested hold-off keeps it
    // low for a long spell counted here
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served <= hold_served + 1;
            hold_left   <= HOLD_OFF_CYCLES;
            m_tready    <= 1'b0;
        end
        else if (recv_gaps)
            m_tready <= ($urandom_range(0, 99) >= 33);
        else
            m_tready <= 1'b1;
    end

    // each result taken is matched against the oldest owed level
    always @(negedge clk)
    begin
        envelope_point_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_points.size() == 0)
                note_error($sformatf("result with nothing owed, level %h flag %b",
                                     m_tdata, m_tuser));
            else
            begin
                want = pending_points.pop_front();
                results_checked++;
                if (m_tdata !== want.level)
                    note_error($sformatf("level mismatch, expected %h got %h",
                                         want.level, m_tdata));
                if (m_tuser !== want.out_of_range)
                    note_error($sformatf("out_of_range mismatch, expected %b got %b",
                                         want.out_of_range, m_tuser));
            end
        end
    end

    // watchdog: too long with nothing taken on either side ends the run
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no request or result taken for %0d cycles",
                         $time, WATCHDOG_LIMIT);
                $display("FAIL");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // reset values read back, and a zero total puts every index out of range
    task automatic test_reset_state();
        check_registers();
        send_request(16'd0);
        send_request(16'hffff);
    endtask

    // hand-picked shapes and the indices on their segment edges
    task automatic test_directed_shapes();
        int plain_edges[9]   = '{0, 100, 101, 150, 151, 320, 321, 399, 400};
        int overlap_edges[5] = '{0, 15, 30, 31, 119};
        // plain adsr, every segment edge
        apply_shape('{mode: MODE_ADSR, atk_len: 16'd100, dcy_len: 16'd50, rel_len: 16'd80,
                      tot_len: 16'd400, peak: 16'd60000, sustain: 16'd20000});
        foreach (plain_edges[k])
            send_request(16'(plain_edges[k]));
        // zero attack, sustain above peak, release longer than the total
        apply_shape('{mode: MODE_ADSR, atk_len: 16'd0, dcy_len: 16'd30, rel_len: 16'd200,
                      tot_len: 16'd120, peak: 16'd1000, sustain: 16'd50000});
        foreach (overlap_edges[k])
            send_request(16'(overlap_edges[k]));
        // asr with attack, release, total and sustain at full scale
        apply_shape('{mode: MODE_ASR, atk_len: 16'hffff, dcy_len: 16'd999, rel_len: 16'hffff,
                      tot_len: 16'hffff, peak: 16'd123, sustain: 16'hffff});
        send_request(16'hfffe);
        send_request(16'd0);
        send_request(16'h8000);
        // segments overlapping at the end of a short attack
        apply_shape('{mode: MODE_ADSR, atk_len: 16'd10, dcy_len: 16'd0, rel_len: 16'd0,
                      tot_len: 16'd10, peak: 16'hffff, sustain: 16'd0});
        send_request(16'd9);
        send_request(16'd10);
    endtask

    // random shapes, the first two at the extremes, each with a burst of indices
    task automatic test_random_shapes(input int phases, input int per_phase);
        envelope_shape_t sh;
        for (int ph = 0; ph < phases; ph++)
        begin
            if (ph == 0)
                sh = '{mode: MODE_ADSR, atk_len: 16'd0, dcy_len: 16'd0, rel_len: 16'd0,
                       tot_len: 16'd0, peak: 16'd0, sustain: 16'd0};
            else if (ph == 1)
                sh = '{mode: MODE_ADSR, atk_len: 16'hffff, dcy_len: 16'hffff,
                       rel_len: 16'hffff, tot_len: 16'hffff, peak: 16'hffff,
                       sustain: 16'hffff};
            else
                sh = random_shape();
            apply_shape(sh);
            repeat (per_phase)
                send_request(pick_index());
        end
    endtask

    // a long stretch at full rate with no idling on either side
    task automatic test_full_rate();
        apply_shape(random_shape());
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        repeat (160)
            send_request(pick_index());
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
    endtask

    // receiver holds off for a long spell while requests keep coming, so the
    // pipe fills and stalls its input; then the sender waits for every level
    task automatic test_backpressure();
        apply_shape(random_shape());
        send_gaps = 1'b0;
        hold_requests++;
        repeat (100)
            send_request(pick_index());
        send_gaps = 1'b1;
        wait_drained();
        repeat (40)
            send_request(pick_index());
    endtask

    initial
    begin
        shape = '{mode: MODE_ADSR, atk_len: '0, dcy_len: '0, rel_len: '0, tot_len: '0,
                  peak: 16'hffff, sustain: 16'h8000};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_directed_shapes();
        test_random_shapes(20, 55);
        test_full_rate();
        test_backpressure();
        test_random_shapes(4, 30);

        wait_drained();
        $display("run covered %0d requests and %0d results over %0d shapes (%0d asr)",
                 requests_sent, results_checked, shapes_applied, asr_shapes);
        $display("indices hit out of range %0d, attack %0d, decay %0d, sustain %0d, release %0d",
                 seg_hits[SEG_OUT], seg_hits[SEG_ATTACK], seg_hits[SEG_DECAY],
                 seg_hits[SEG_SUSTAIN], seg_hits[SEG_RELEASE]);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
